>>> rtl/energy_counter_extend_scale_unit_macros.svh
// ---------------------------------------------------------------------------
// energy counter extend scale: assertion macros
// shared assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef ENERGY_COUNTER_EXTEND_SCALE_UNIT_MACROS_SVH
`define ENERGY_COUNTER_EXTEND_SCALE_UNIT_MACROS_SVH

// checked outside reset
`define ECS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ECS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ecs_pkg.sv
// ---------------------------------------------------------------------------
// ecs_pkg
// types and constants of the energy counter extend scale unit
// ---------------------------------------------------------------------------
package ecs_pkg;

   localparam int unsigned RAW_W    = 32;
   localparam int unsigned EXT_W    = 32;
   localparam int unsigned FACTOR_W = 32;
   localparam int unsigned SLOT_W   = 3;
   localparam int unsigned NUM_SLOTS = 1 << SLOT_W;
   localparam int unsigned VALUE_W  = EXT_W + RAW_W;
   // factor times ten needs four more bits
   localparam int unsigned MPLR_W   = FACTOR_W + 4;
   localparam int unsigned MUL_STEPS = MPLR_W;
   localparam int unsigned CNT_W    = $clog2(MUL_STEPS + 1);
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [RAW_W-1:0] HIGH_MARK = 32'hA000_0000;
   localparam logic [RAW_W-1:0] LOW_MARK  = 32'h6000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FACTOR_ONE = 1'b0,
      CSR_FACTOR_TWO = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_BUSY = 1'b1
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

>>> rtl/energy_counter_extend_scale_unit.sv
// ---------------------------------------------------------------------------
// energy_counter_extend_scale_unit
// wraparound extension and scaling of raw energy accumulator readings
// ---------------------------------------------------------------------------
// usage
//   req channel: a word carries channel, energy kind and a raw 32-bit
//   accumulator reading; taken when req_valid and req_ready are both high
//   rsp channel: one word per request, the scaled energy in milli units
//   csr port: csr_write_enable writes csr_write_data to factor one (index 0)
//   or factor two (index 1) at once; only write while the unit is idle
//   latency: 37 cycles from request acceptance to rsp_valid
//   throughput: one word every 38 cycles, set by the 36-step bit-serial
//   multiplier (factor times ten is 36 bits, one bit per cycle)
//   a finished word sits in the output register, so a new request is
//   taken while the receiver stalls; a second result then waits in the
//   multiplier until the output register frees
//   reset: synchronous; clears factors, the eight last readings and wrap
//   extensions, and drops rsp_valid
// ---------------------------------------------------------------------------
module energy_counter_extend_scale_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_channel,
   input  logic [1:0]                       req_energy_kind,
   input  logic [ecs_pkg::RAW_W-1:0]        req_raw_count,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [31:0]               rsp_energy_milli,
   // configuration
   input  logic                             csr_write_enable,
   input  logic [ecs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ecs_pkg::FACTOR_W-1:0]     csr_write_data
);
   import ecs_pkg::*;

   state_type            state_ff, state_in;
   logic [FACTOR_W-1:0]  factor_one_ff, factor_two_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic                 out_free;
   logic [SLOT_W-1:0]    slot;
   logic [EXT_W-1:0]     ext_next;
   logic [FACTOR_W-1:0]  factor_sel;
   logic [MPLR_W-1:0]    factor_x10;
   logic [VALUE_W-1:0]   value;
   mul_status_type       mul_status;
   logic [VALUE_W-1:0]   product;

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign slot       = {req_channel, req_energy_kind};

   // factor registers
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_one_ff <= '0;
         factor_two_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FACTOR_ONE: factor_one_ff <= csr_write_data;
            CSR_FACTOR_TWO: factor_two_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // per slot reading history and wrap count
   ecs_slot_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_accept),
      .slot     (slot),
      .raw      (req_raw_count),
      .ext_next (ext_next)
   );

   // extended value and factor times ten (8x + 2x)
   assign value      = {ext_next, req_raw_count};
   assign factor_sel = req_channel ? factor_two_ff : factor_one_ff;
   assign factor_x10 = {1'b0, factor_sel, 3'b000} + {3'b000, factor_sel, 1'b0};

   ecs_serial_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .operand    (value),
      .multiplier (factor_x10),
      .status     (mul_status),
      .product    (product)
   );

   // control: one word in flight in the multiplier
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            // hand over bits 63:32 once the output register is free
            if (mul_status.done && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = product[VALUE_W-1:RAW_W];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_energy_milli = signed'(rsp_data_ff);

endmodule

>>> rtl/ecs_slot_tracker.sv
// ---------------------------------------------------------------------------
// ecs_slot_tracker
// last reading and wrap extension per channel and kind
// ---------------------------------------------------------------------------
module ecs_slot_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [ecs_pkg::SLOT_W-1:0]  slot,
   input  logic [ecs_pkg::RAW_W-1:0]   raw,
   output logic [ecs_pkg::EXT_W-1:0]   ext_next
);
   import ecs_pkg::*;

   logic [RAW_W-1:0] last_ff [NUM_SLOTS];
   logic [EXT_W-1:0] ext_ff  [NUM_SLOTS];
   logic [RAW_W-1:0] prev;
   logic [EXT_W-1:0] ext_cur;
   logic             wrap_up;
   logic             wrap_down;

   assign prev      = last_ff[slot];
   assign ext_cur   = ext_ff[slot];
   // strict compares, boundary values never count
   assign wrap_up   = (prev > HIGH_MARK) && (raw < LOW_MARK);
   assign wrap_down = (prev < LOW_MARK) && (raw > HIGH_MARK);

   always_comb begin
      if (wrap_up) begin
         ext_next = ext_cur + EXT_W'(1);
      end else if (wrap_down) begin
         ext_next = ext_cur - EXT_W'(1);
      end else begin
         ext_next = ext_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            last_ff[SLOT_W'(i)] <= '0;
            ext_ff[SLOT_W'(i)]  <= '0;
         end
      end else if (wr_en) begin
         last_ff[slot] <= raw;
         ext_ff[slot]  <= ext_next;
      end
   end

endmodule

>>> rtl/ecs_serial_mul.sv
// ---------------------------------------------------------------------------
// ecs_serial_mul
// bit-serial shift-add multiplier, product modulo 2^64
// ---------------------------------------------------------------------------
module ecs_serial_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ecs_pkg::VALUE_W-1:0]   operand,
   input  logic [ecs_pkg::MPLR_W-1:0]    multiplier,
   output ecs_pkg::mul_status_type       status,
   output logic [ecs_pkg::VALUE_W-1:0]   product
);
   import ecs_pkg::*;

   logic [VALUE_W-1:0] acc_ff,   acc_in;
   logic [VALUE_W-1:0] mcand_ff, mcand_in;
   logic [MPLR_W-1:0]  mplr_ff,  mplr_in;
   logic [CNT_W-1:0]   cnt_ff,   cnt_in;
   logic               busy_ff,  busy_in;

   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mplr_in  = mplr_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (start) begin
         acc_in   = '0;
         mcand_in = operand;
         mplr_in  = multiplier;
         cnt_in   = CNT_W'(MUL_STEPS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // one multiplier bit per cycle
         if (mplr_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = {mcand_ff[VALUE_W-2:0], 1'b0};
         mplr_in  = {1'b0, mplr_ff[MPLR_W-1:1]};
         cnt_in   = cnt_ff - CNT_W'(1);
         busy_in  = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = !busy_ff;
   assign product     = acc_ff;

endmodule

>>> rtl/ecs_checker.sv
// ---------------------------------------------------------------------------
// ecs_checker
// port-level checks of the energy counter extend scale unit
// ---------------------------------------------------------------------------
`include "energy_counter_extend_scale_unit_macros.svh"

module ecs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_energy_milli
);

   // stalled word holds
   `ECS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_energy_milli), "rsp word changed under stall")
   // one word at a time through the multiplier
   `ECS_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready ##1 !req_ready, "request taken while busy")
   // a fresh result always frees the request side
   `ECS_ASSERT(a_rsp_with_ready, clock, reset, $rose(rsp_valid) |-> req_ready, "result shown while still busy")
   // reset drops the response
   `ECS_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "rsp_valid after reset")

endmodule

bind energy_counter_extend_scale_unit ecs_checker u_ecs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_energy_milli (rsp_energy_milli)
);
